// ===== design/bavg_pkg.sv =====
// ----------------------------------------------------------------------------
// Block average downscaler package
// Shared widths, register indexes, the flag bundle that travels with each
// queued pixel and the per-channel halving average.
// ----------------------------------------------------------------------------
package bavg_pkg;

	localparam int CH_W        = 8;
	localparam int LANES       = 4;
	localparam int PIX_W       = CH_W * LANES;
	localparam int SCALE_REG_W = 7;
	localparam int DIM_REG_W   = 13;
	localparam int MAX_HEIGHT  = 4096;
	localparam int ROW_W       = 12;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CFG_SCALE  = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef struct packed {
		logic first;
		logic emit;
		logic row_end;
		logic frame_end;
	} bavg_flags_t;

	localparam int FLAGS_W = $bits(bavg_flags_t);

	// floor((acc + px) / 2) in every channel lane.
	function automatic logic [PIX_W-1:0] avg_px(input logic [PIX_W-1:0] acc,
	                                            input logic [PIX_W-1:0] px);
		logic [CH_W:0]      sum;
		logic [PIX_W-1:0]   res;
		res = '0;
		for (int k = 0; k < LANES; k++) begin
			sum = {1'b0, acc[k*CH_W +: CH_W]} + {1'b0, px[k*CH_W +: CH_W]};
			res[k*CH_W +: CH_W] = sum[CH_W:1];
		end
		return res;
	endfunction

endpackage

// ===== design/bavg_front.sv =====
// ----------------------------------------------------------------------------
// Block average downscaler front end
// Tracks the raster position of each accepted pixel and tags it with its
// accumulator column and its first, emit, row end and frame end flags.
// ----------------------------------------------------------------------------
module bavg_front #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_SCALE = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bavg_pkg::SCALE_REG_W-1:0]    scale_reg,
	input  logic [bavg_pkg::DIM_REG_W-1:0]      width_reg,
	input  logic [bavg_pkg::DIM_REG_W-1:0]      height_reg,
	input  logic                                push,
	output bavg_pkg::bavg_flags_t               flags,
	output logic [$clog2(MAX_WIDTH)-1:0]        oc
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int SW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int XW  = ($clog2(MAX_WIDTH + 1) > bavg_pkg::DIM_REG_W) ?
	                     $clog2(MAX_WIDTH + 1) : bavg_pkg::DIM_REG_W;
	localparam int XS  = ($clog2(MAX_SCALE + 1) > bavg_pkg::SCALE_REG_W) ?
	                     $clog2(MAX_SCALE + 1) : bavg_pkg::SCALE_REG_W;
	localparam int HW  = bavg_pkg::DIM_REG_W;

	logic [CW-1:0]               src_col_q;
	logic [CW-1:0]               out_col_q;
	logic [bavg_pkg::ROW_W-1:0]  src_row_q;
	logic [SW-1:0]               col_blk_q;
	logic [SW-1:0]               row_blk_q;

	logic [XW-1:0] w_reg_x, w_lim;
	logic [XS-1:0] s_reg_x, s_lim;
	logic [HW-1:0] h_lim;
	logic          last_col, last_row, blk_col_end, blk_row_end;

	// Registers that read zero act as one; oversized values saturate.
	always_comb begin
		w_reg_x = XW'(width_reg);
		s_reg_x = XS'(scale_reg);
		if (width_reg == '0) begin
			w_lim = XW'(1);
		end else if (w_reg_x > XW'(MAX_WIDTH)) begin
			w_lim = XW'(MAX_WIDTH);
		end else begin
			w_lim = w_reg_x;
		end
		if (scale_reg == '0) begin
			s_lim = XS'(1);
		end else if (s_reg_x > XS'(MAX_SCALE)) begin
			s_lim = XS'(MAX_SCALE);
		end else begin
			s_lim = s_reg_x;
		end
		if (height_reg == '0) begin
			h_lim = HW'(1);
		end else if (height_reg > HW'(bavg_pkg::MAX_HEIGHT)) begin
			h_lim = HW'(bavg_pkg::MAX_HEIGHT);
		end else begin
			h_lim = height_reg;
		end
	end

	assign last_col    = XW'(src_col_q) >= (w_lim - XW'(1));
	assign last_row    = HW'(src_row_q) >= (h_lim - HW'(1));
	assign blk_col_end = XS'(col_blk_q) >= (s_lim - XS'(1));
	assign blk_row_end = XS'(row_blk_q) >= (s_lim - XS'(1));

	assign oc              = out_col_q;
	assign flags.first     = (col_blk_q == '0) && (row_blk_q == '0);
	assign flags.emit      = (blk_col_end || last_col) && (blk_row_end || last_row);
	assign flags.row_end   = last_col;
	assign flags.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			out_col_q <= '0;
			src_row_q <= '0;
			col_blk_q <= '0;
			row_blk_q <= '0;
		end else if (push) begin
			if (last_col) begin
				src_col_q <= '0;
				col_blk_q <= '0;
				out_col_q <= '0;
				if (last_row) begin
					src_row_q <= '0;
					row_blk_q <= '0;
				end else begin
					src_row_q <= src_row_q + 1'b1;
					row_blk_q <= blk_row_end ? '0 : row_blk_q + 1'b1;
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				if (blk_col_end) begin
					col_blk_q <= '0;
					out_col_q <= out_col_q + 1'b1;
				end else begin
					col_blk_q <= col_blk_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/bavg_queue.sv =====
// ----------------------------------------------------------------------------
// Block average downscaler queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bavg_queue #(
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output logic [DW-1:0] pop_data
);

	logic [DW-1:0]                entry_q [bavg_pkg::QUEUE_DEPTH];
	logic [bavg_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [bavg_pkg::QCNT_W-1:0]  count_q;

	assign full     = count_q == bavg_pkg::QCNT_W'(bavg_pkg::QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign pop_data = entry_q[rd_ptr_q];

	function automatic logic [bavg_pkg::QPTR_W-1:0] next_ptr(
			input logic [bavg_pkg::QPTR_W-1:0] p);
		if (p == bavg_pkg::QPTR_W'(bavg_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/bavg_back.sv =====
// ----------------------------------------------------------------------------
// Block average downscaler back end
// Read-modify-write of the column accumulator memory with a write-to-read
// bypass, and the output register of the result stream.
// ----------------------------------------------------------------------------
module bavg_back #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  bavg_pkg::bavg_flags_t               q_flags,
	input  logic [$clog2(MAX_WIDTH)-1:0]        q_oc,
	input  logic [bavg_pkg::PIX_W-1:0]          q_px,
	output logic                                q_pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bavg_pkg::PIX_W-1:0]          m_tdata,
	output logic                                m_tlast,
	output logic                                m_tuser
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [bavg_pkg::PIX_W-1:0] acc_mem [MAX_WIDTH];

	logic                        valid_s1;
	bavg_pkg::bavg_flags_t       flags_s1;
	logic [CW-1:0]               oc_s1;
	logic [bavg_pkg::PIX_W-1:0]  px_s1, rd_s1, fwd_acc_s1;
	logic                        fwd_hit_s1;

	logic                        out_valid_q, out_last_q, out_frame_q;
	logic [bavg_pkg::PIX_W-1:0]  out_data_q;

	logic [bavg_pkg::PIX_W-1:0]  acc_src, acc;
	logic                        out_free, fire_s1, ready_s1;

	// The entry written at the edge that also reads it comes from the bypass.
	assign acc_src  = fwd_hit_s1 ? fwd_acc_s1 : rd_s1;
	assign acc      = flags_s1.first ? px_s1 : bavg_pkg::avg_px(acc_src, px_s1);
	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && (!flags_s1.emit || out_free);
	assign ready_s1 = !valid_s1 || fire_s1;
	assign q_pop    = q_valid && ready_s1;

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			acc_mem[oc_s1] <= acc;
		end
		if (q_pop) begin
			rd_s1 <= acc_mem[q_oc];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_s1   <= q_flags;
			oc_s1      <= q_oc;
			px_s1      <= q_px;
			fwd_hit_s1 <= fire_s1 && (q_oc == oc_s1);
			fwd_acc_s1 <= acc;
		end
		if (fire_s1 && flags_s1.emit) begin
			out_data_q  <= acc;
			out_last_q  <= flags_s1.row_end;
			out_frame_q <= flags_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= q_valid;
			end
			if (fire_s1 && flags_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_frame_q;

endmodule

// ===== design/block_average_downscaler_core.sv =====
// ----------------------------------------------------------------------------
// Block average downscaler core
// Box-filter image shrink by an integer factor with a running halving average.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order as one request per cycle on the slave
// stream while the queue has room, and one output pixel leaves on the master
// stream for every finished scale-by-scale block, so an image of W by H
// pixels yields ceil(W/s) by ceil(H/s) outputs. The block sustains one pixel
// per clock while the master stream is not stalled: every pixel costs a single
// read-modify-write of its column accumulator, done in one back-end stage
// whose memory port reads one entry and writes one entry each cycle, with a
// bypass covering a pixel that follows its neighbor in the same block. An
// output pixel passes through the queue, the back-end stage and the output
// register before it is presented on the master stream. The accumulator
// memory is not cleared after reset; the first pixel of every block loads its
// entry, so no clearing pass is needed. Registers (scale at 0x0, width at 0x4,
// height at 0x8) are meant to be written between frames; a zero acts as one
// and oversized values saturate. m_tlast marks the last output pixel of an
// output row and m_tuser marks the last output pixel of the frame.
// ----------------------------------------------------------------------------
module block_average_downscaler_core #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_SCALE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bavg_pkg::ADDR_W-1:0]    paddr,
	input  logic [bavg_pkg::DATA_W-1:0]    pwdata,
	output logic [bavg_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	// Source pixels
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bavg_pkg::PIX_W-1:0]     s_tdata,  // channel_a, channel_b, channel_g, channel_r
	// Output pixels
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bavg_pkg::PIX_W-1:0]     m_tdata,  // out_a, out_b, out_g, out_r
	output logic                           m_tlast,  // row_end
	output logic                           m_tuser   // frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = bavg_pkg::FLAGS_W + CW + bavg_pkg::PIX_W;

	logic [bavg_pkg::SCALE_REG_W-1:0] scale_q;
	logic [bavg_pkg::DIM_REG_W-1:0]   width_q, height_q;
	logic                             cfg_wr;

	bavg_pkg::bavg_flags_t push_flags, pop_flags;
	logic [CW-1:0]                    push_oc, pop_oc;
	logic [bavg_pkg::PIX_W-1:0]       pop_px;
	logic [QW-1:0]                    push_data, pop_data;
	logic                             q_push, q_full, q_pop, q_valid;

	// Configuration registers; pready is always high, so the access cycle
	// of a write request completes it.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bavg_pkg::SCALE_REG_W'(1);
			width_q  <= bavg_pkg::DIM_REG_W'(1);
			height_q <= bavg_pkg::DIM_REG_W'(1);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bavg_pkg::CFG_SCALE:  scale_q  <= pwdata[bavg_pkg::SCALE_REG_W-1:0];
				bavg_pkg::CFG_WIDTH:  width_q  <= pwdata[bavg_pkg::DIM_REG_W-1:0];
				bavg_pkg::CFG_HEIGHT: height_q <= pwdata[bavg_pkg::DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bavg_pkg::CFG_SCALE:  prdata = bavg_pkg::DATA_W'(scale_q);
			bavg_pkg::CFG_WIDTH:  prdata = bavg_pkg::DATA_W'(width_q);
			bavg_pkg::CFG_HEIGHT: prdata = bavg_pkg::DATA_W'(height_q);
			default:              prdata = '0;
		endcase
	end

	// The front end takes a pixel whenever the queue has room; the back end
	// drains the queue independently of that.
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && s_tready;

	bavg_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_reg  (scale_q),
		.width_reg  (width_q),
		.height_reg (height_q),
		.push       (q_push),
		.flags      (push_flags),
		.oc         (push_oc)
	);

	assign push_data = {push_flags, push_oc, s_tdata};

	bavg_queue #(
		.DW (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	assign pop_flags = pop_data[QW-1 -: bavg_pkg::FLAGS_W];
	assign pop_oc    = pop_data[bavg_pkg::PIX_W +: CW];
	assign pop_px    = pop_data[bavg_pkg::PIX_W-1:0];

	bavg_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_flags  (pop_flags),
		.q_oc     (pop_oc),
		.q_px     (pop_px),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// A frame's last output pixel is always also the last of its row.
	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("frame end without row end");

	// The back end only takes entries the queue actually holds.
	a_pop_only_when_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// A pixel that closes the frame always closes a block and a row.
	a_frame_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && push_flags.frame_end |-> push_flags.emit && push_flags.row_end)
		else $error("frame end pixel does not emit");

endmodule
